// File: rtl/srt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types, widths and codes of the sorted record table.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W     = 2;
  localparam int KEY_W    = 16;
  localparam int PRICE_W  = 24;
  localparam int STOCK_W  = 16;
  localparam int OCOUNT_W = 7;
  localparam int ENTRY_W  = KEY_W + PRICE_W + STOCK_W;

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [OCOUNT_W-1:0] ocount_t;
  typedef logic [OP_W-1:0]     op_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_LOOKUP = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  localparam cnt_t                CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [ADDR_W:0]     CAP_WRAP = (ADDR_W + 1)'(CAPACITY);

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [STOCK_W-1:0] stock;
  } entry_t;

  typedef struct packed {
    logic         we;
    addr_t        waddr;
    entry_t       wdata;
    logic         re;
    addr_t        raddr;
  } ram_req_t;

  typedef struct packed {
    logic               ok;
    logic [PRICE_W-1:0] found_price;
    logic [STOCK_W-1:0] found_stock;
    ocount_t            entry_count;
    logic               is_empty;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_INS_WR,
    ST_LOOK,
    ST_DONE
  } state_t;

  // circular buffer: logical position to physical memory address
  function automatic addr_t phys_addr(addr_t base, addr_t offs);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= CAP_WRAP) begin
      sum = sum - CAP_WRAP;
    end
    return addr_t'(sum);
  endfunction

endpackage

// File: rtl/srt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_in_if
// Request channel of the sorted record table: valid, ready and request fields.
// ----------------------------------------------------------------------------
interface srt_in_if;
  logic                        valid;
  logic                        ready;
  logic [srt_pkg::OP_W-1:0]    operation;
  logic [srt_pkg::KEY_W-1:0]   key;
  logic [srt_pkg::PRICE_W-1:0] price_cents;
  logic [srt_pkg::STOCK_W-1:0] stock_count;

  modport source (output valid, operation, key, price_cents, stock_count, input ready);
  modport sink   (input valid, operation, key, price_cents, stock_count, output ready);
endinterface

// File: rtl/srt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_out_if
// Result channel of the sorted record table: valid, ready and result fields.
// ----------------------------------------------------------------------------
interface srt_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [srt_pkg::PRICE_W-1:0]  found_price;
  logic [srt_pkg::STOCK_W-1:0]  found_stock;
  logic [srt_pkg::OCOUNT_W-1:0] entry_count;
  logic                         is_empty;

  modport source (output valid, ok, found_price, found_stock, entry_count, is_empty,
                  input ready);
  modport sink   (input valid, ok, found_price, found_stock, entry_count, is_empty,
                  output ready);
endinterface

// File: rtl/sorted_record_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_record_table
// Bounded table of records kept in ascending key order, held in one RAM.
// ----------------------------------------------------------------------------
// in_ch carries requests (insert, look up, remove head); out_ch returns one
// result per request with ok, the found price and stock, the entry count and
// an empty flag. Both are valid/ready channels; a transfer is a cycle with
// valid and ready high.
// The records sit in a 64-entry ring in a single RAM with a registered read
// port; a head pointer lets remove just advance the head. Insert reads the
// tail first and moves every entry that goes after the new record up by one,
// one entry per cycle, then writes the record. Lookup walks from the head,
// one entry a cycle, up to the first equal key or the last entry. One request
// is in work at a time; the next is taken once the result leaves the sequencer.
// A result register sits before out_ch, so a new request is taken while the
// last result waits for the receiver; a stall holds the result there and the
// sequencer waits at its end. Reset empties the table at once.
// ----------------------------------------------------------------------------
module sorted_record_table (
  input  logic       clk,
  input  logic       rst_n,
  srt_in_if.sink     in_ch,
  srt_out_if.source  out_ch
);

  srt_pkg::ram_req_t ram_req;
  srt_pkg::entry_t   rd_entry;
  logic [srt_pkg::ENTRY_W-1:0] rd_data;
  logic              res_valid;
  logic              res_ready;
  srt_pkg::result_t  res;

  logic              out_valid_r;
  srt_pkg::result_t  out_r;

  assign rd_entry = srt_pkg::entry_t'(rd_data);

  srt_ram #(
    .DEPTH (srt_pkg::CAPACITY),
    .WIDTH (srt_pkg::ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.we),
    .wr_addr (ram_req.waddr),
    .wr_data (ram_req.wdata),
    .rd_en   (ram_req.re),
    .rd_addr (ram_req.raddr),
    .rd_data (rd_data)
  );

  srt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ram_req   (ram_req),
    .rd_entry  (rd_entry),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // result register
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_r.ok;
  assign out_ch.found_price = out_r.found_price;
  assign out_ch.found_stock = out_r.found_stock;
  assign out_ch.entry_count = out_r.entry_count;
  assign out_ch.is_empty    = out_r.is_empty;

endmodule

// File: rtl/srt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module srt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 56
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/srt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_ctrl
// Sequencer of the table: ring head, fill count, shift-up insert, lookup walk.
// ----------------------------------------------------------------------------
module srt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  srt_in_if.sink             in_ch,
  output srt_pkg::ram_req_t  ram_req,
  input  srt_pkg::entry_t    rd_entry,
  output logic               res_valid,
  input  logic               res_ready,
  output srt_pkg::result_t   res
);

  srt_pkg::state_t state_r, state_nxt;
  srt_pkg::addr_t  head_r, head_nxt;
  srt_pkg::cnt_t   fill_r, fill_nxt;
  srt_pkg::addr_t  idx_r, idx_nxt;
  srt_pkg::addr_t  pos_r, pos_nxt;
  srt_pkg::entry_t rec_r, rec_nxt;
  logic            ok_r, ok_nxt;
  logic [srt_pkg::PRICE_W-1:0] found_price_r, found_price_nxt;
  logic [srt_pkg::STOCK_W-1:0] found_stock_r, found_stock_nxt;

  logic in_fire;
  logic full;
  logic empty;
  logic move;
  logic hit;
  logic last;

  assign in_ch.ready = (state_r == srt_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign full        = (fill_r == srt_pkg::CAP_CNT);
  assign empty       = (fill_r == '0);

  // shift while the stored key is not smaller; the head moves only for a smaller key
  assign move = (idx_r != '0) ? (rd_entry.key >= rec_r.key) : (rec_r.key < rd_entry.key);
  assign hit  = (rd_entry.key == rec_r.key);
  assign last = (({1'b0, idx_r} + srt_pkg::CNT_W'(1)) == fill_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srt_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.operation)
            srt_pkg::OP_INSERT: begin
              if (full) begin
                state_nxt = srt_pkg::ST_DONE;
              end else if (empty) begin
                state_nxt = srt_pkg::ST_INS_WR;
              end else begin
                state_nxt = srt_pkg::ST_SHIFT;
              end
            end
            srt_pkg::OP_LOOKUP: begin
              state_nxt = empty ? srt_pkg::ST_DONE : srt_pkg::ST_LOOK;
            end
            default: state_nxt = srt_pkg::ST_DONE;
          endcase
        end
      end
      srt_pkg::ST_SHIFT: begin
        if (!(move && (idx_r != '0))) begin
          state_nxt = srt_pkg::ST_INS_WR;
        end
      end
      srt_pkg::ST_INS_WR: state_nxt = srt_pkg::ST_DONE;
      srt_pkg::ST_LOOK: begin
        if (hit || last) begin
          state_nxt = srt_pkg::ST_DONE;
        end
      end
      srt_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = srt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srt_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    rec_nxt         = rec_r;
    ok_nxt          = ok_r;
    found_price_nxt = found_price_r;
    found_stock_nxt = found_stock_r;
    ram_req         = '0;
    ram_req.wdata   = rec_r;
    unique case (state_r)
      srt_pkg::ST_IDLE: begin
        if (in_fire) begin
          rec_nxt.key     = in_ch.key;
          rec_nxt.price   = in_ch.price_cents;
          rec_nxt.stock   = in_ch.stock_count;
          ok_nxt          = 1'b0;
          found_price_nxt = '0;
          found_stock_nxt = '0;
          unique case (in_ch.operation)
            srt_pkg::OP_INSERT: begin
              if (!full && empty) begin
                pos_nxt = '0;
              end else if (!full) begin
                idx_nxt       = srt_pkg::addr_t'(fill_r - srt_pkg::CNT_W'(1));
                ram_req.re    = 1'b1;
                ram_req.raddr = srt_pkg::phys_addr(head_r, idx_nxt);
              end
            end
            srt_pkg::OP_LOOKUP: begin
              if (!empty) begin
                idx_nxt       = '0;
                ram_req.re    = 1'b1;
                ram_req.raddr = head_r;
              end
            end
            srt_pkg::OP_REMOVE: begin
              if (!empty) begin
                head_nxt = srt_pkg::phys_addr(head_r, srt_pkg::ADDR_W'(1));
                fill_nxt = fill_r - srt_pkg::CNT_W'(1);
                ok_nxt   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      srt_pkg::ST_SHIFT: begin
        if (move) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = srt_pkg::phys_addr(head_r, idx_r + srt_pkg::ADDR_W'(1));
          ram_req.wdata = rd_entry;
          if (idx_r != '0) begin
            idx_nxt       = idx_r - srt_pkg::ADDR_W'(1);
            ram_req.re    = 1'b1;
            ram_req.raddr = srt_pkg::phys_addr(head_r, idx_nxt);
          end else begin
            pos_nxt = '0;
          end
        end else begin
          pos_nxt = idx_r + srt_pkg::ADDR_W'(1);
        end
      end
      srt_pkg::ST_INS_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = srt_pkg::phys_addr(head_r, pos_r);
        fill_nxt      = fill_r + srt_pkg::CNT_W'(1);
        ok_nxt        = 1'b1;
      end
      srt_pkg::ST_LOOK: begin
        if (hit) begin
          ok_nxt          = 1'b1;
          found_price_nxt = rd_entry.price;
          found_stock_nxt = rd_entry.stock;
        end else if (!last) begin
          idx_nxt       = idx_r + srt_pkg::ADDR_W'(1);
          ram_req.re    = 1'b1;
          ram_req.raddr = srt_pkg::phys_addr(head_r, idx_nxt);
        end
      end
      srt_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // result view
  always_comb begin
    res_valid       = (state_r == srt_pkg::ST_DONE);
    res.ok          = ok_r;
    res.found_price = found_price_r;
    res.found_stock = found_stock_r;
    res.entry_count = srt_pkg::ocount_t'(fill_r);
    res.is_empty    = empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srt_pkg::ST_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    pos_r         <= pos_nxt;
    rec_r         <= rec_nxt;
    ok_r          <= ok_nxt;
    found_price_r <= found_price_nxt;
    found_stock_r <= found_stock_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= srt_pkg::CAP_CNT)
    else $error("fill count above capacity");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.operation == srt_pkg::OP_REMOVE) && !empty)
      |=> (fill_r == $past(fill_r) - srt_pkg::CNT_W'(1)))
    else $error("remove did not drop the fill count");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srt_pkg::ST_IDLE || state_r == srt_pkg::ST_DONE) |-> !ram_req.we)
    else $error("memory write outside an insert");

  a_shift_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srt_pkg::ST_SHIFT) |-> (!empty && !full))
    else $error("shift with no room or no entries");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.ok) |-> (res.found_price == '0 && res.found_stock == '0))
    else $error("failed result carries record data");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sorted record table against an in-bench copy of the table.
// Directed transfers cover the empty table, key and field extremes, equal
// keys and the unused code. Random traffic alternates fill and drain phases
// so the table reaches full and empty. A long receiver hold-off fills the
// pipeline and stalls the input. Every result is compared with the
// prediction made when its request transfer completed.
// ----------------------------------------------------------------------------
module testbench;

  localparam srt_pkg::op_t OP_UNUSED = 2'd3;
  localparam int           HOLD_LEN  = 300;

  logic clk;
  logic rst_n;

  srt_in_if  in_ch ();
  srt_out_if out_ch ();

  sorted_record_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  srt_pkg::entry_t  shelf_rec [srt_pkg::CAPACITY];
  int unsigned      shelf_fill;
  srt_pkg::result_t due_results [$];
  int               fault_count;
  bit               calm;
  int               hold_asked;
  int               hold_done;
  int               hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // applies one request to the table copy and returns the result it gives
  function automatic srt_pkg::result_t apply_to_shelf(srt_pkg::op_t op,
                                                      logic [srt_pkg::KEY_W-1:0] k,
                                                      logic [srt_pkg::PRICE_W-1:0] p,
                                                      logic [srt_pkg::STOCK_W-1:0] s);
    srt_pkg::result_t r;
    int               pos;
    bit               hit;
    r   = '0;
    hit = 1'b0;
    case (op)
      srt_pkg::OP_INSERT: begin
        if (shelf_fill < srt_pkg::CAPACITY) begin
          if (shelf_fill == 0 || k < shelf_rec[0].key) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < shelf_fill && shelf_rec[pos].key < k) pos++;
          end
          for (int i = shelf_fill; i > pos; i--) shelf_rec[i] = shelf_rec[i-1];
          shelf_rec[pos] = {k, p, s};
          shelf_fill++;
          r.ok = 1'b1;
        end
      end
      srt_pkg::OP_LOOKUP: begin
        for (int i = 0; i < shelf_fill; i++) begin
          if (!hit && shelf_rec[i].key == k) begin
            hit           = 1'b1;
            r.ok          = 1'b1;
            r.found_price = shelf_rec[i].price;
            r.found_stock = shelf_rec[i].stock;
          end
        end
      end
      srt_pkg::OP_REMOVE: begin
        if (shelf_fill > 0) begin
          for (int i = 1; i < shelf_fill; i++) shelf_rec[i-1] = shelf_rec[i];
          shelf_fill--;
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = srt_pkg::ocount_t'(shelf_fill);
    r.is_empty    = (shelf_fill == 0);
    return r;
  endfunction

  task automatic send_item(srt_pkg::op_t op, logic [srt_pkg::KEY_W-1:0] k,
                           logic [srt_pkg::PRICE_W-1:0] p,
                           logic [srt_pkg::STOCK_W-1:0] s);
    while (!calm && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.key         <= k;
    in_ch.price_cents <= p;
    in_ch.stock_count <= s;
    do @(posedge clk); while (!in_ch.ready);
    due_results.push_back(apply_to_shelf(op, k, p, s));
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [srt_pkg::KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return srt_pkg::KEY_W'($urandom_range(15));
    if (roll < 48) return '0;
    if (roll < 51) return '1;
    return srt_pkg::KEY_W'($urandom);
  endfunction

  function automatic logic [srt_pkg::KEY_W-1:0] lookup_key();
    if (shelf_fill > 0 && $urandom_range(99) < 60) begin
      return shelf_rec[srt_pkg::ADDR_W'($urandom_range(shelf_fill - 1))].key;
    end
    return pick_key();
  endfunction

  // fill phases favor insert, drain phases favor remove
  function automatic srt_pkg::op_t pick_op(bit filling);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return OP_UNUSED;
    if (filling) begin
      if (roll < 85) return srt_pkg::OP_INSERT;
      if (roll < 95) return srt_pkg::OP_LOOKUP;
      return srt_pkg::OP_REMOVE;
    end
    if (roll < 13) return srt_pkg::OP_INSERT;
    if (roll < 25) return srt_pkg::OP_LOOKUP;
    return srt_pkg::OP_REMOVE;
  endfunction

  task automatic send_random(bit filling);
    srt_pkg::op_t op;
    op = pick_op(filling);
    send_item(op, (op == srt_pkg::OP_LOOKUP) ? lookup_key() : pick_key(),
              srt_pkg::PRICE_W'($urandom), srt_pkg::STOCK_W'($urandom));
  endtask

  task automatic test_empty_table();
    send_item(srt_pkg::OP_LOOKUP, '0, '0, '0);
    send_item(srt_pkg::OP_REMOVE, '1, '1, '1);
    send_item(OP_UNUSED, 16'h5a5a, 24'ha5a5a5, 16'h5a5a);
    wait_quiet();
  endtask

  task automatic test_field_extremes();
    send_item(srt_pkg::OP_INSERT, '1, '1, '1);
    send_item(srt_pkg::OP_INSERT, '0, '0, '0);
    send_item(srt_pkg::OP_INSERT, 16'h8000, 24'h800000, 16'h8000);
    send_item(srt_pkg::OP_LOOKUP, '0, '0, '0);
    send_item(srt_pkg::OP_LOOKUP, '1, '0, '0);
    send_item(srt_pkg::OP_LOOKUP, 16'h8000, '1, '1);
    send_item(srt_pkg::OP_LOOKUP, 16'h1234, '0, '0);
    send_item(OP_UNUSED, '1, '1, '1);
    wait_quiet();
  endtask

  task automatic test_equal_keys();
    // a repeated key goes ahead of its stored equal key (only the head keeps its place)
    send_item(srt_pkg::OP_INSERT, '0, 24'h123456, 16'h0101);
    send_item(srt_pkg::OP_INSERT, 16'd500, 24'h000111, 16'h0011);
    send_item(srt_pkg::OP_INSERT, 16'd500, 24'h000222, 16'h0022);
    send_item(srt_pkg::OP_LOOKUP, '0, '0, '0);
    send_item(srt_pkg::OP_LOOKUP, 16'd500, '0, '0);
    send_item(srt_pkg::OP_REMOVE, '0, '0, '0);
    send_item(srt_pkg::OP_LOOKUP, '0, '0, '0);
    wait_quiet();
  endtask

  task automatic test_drain_to_empty();
    while (shelf_fill > 0) send_item(srt_pkg::OP_REMOVE, '0, '0, '0);
    send_item(srt_pkg::OP_REMOVE, '0, '0, '0);
    send_item(srt_pkg::OP_LOOKUP, '1, '0, '0);
    wait_quiet();
  endtask

  task automatic test_output_backpressure();
    @(posedge clk);
    hold_asked <= hold_asked + 1;
    repeat (30) send_random(1'b1);
    wait_quiet();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      calm = (phase == 2);
      repeat (116) send_random(phase % 2 == 0);
    end
    calm = 1'b0;
    wait_quiet();
  endtask

  // receiver: random ready, or a counted hold-off when one is asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_done != hold_asked) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_LEN;
      hold_done    <= hold_asked;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    srt_pkg::result_t got;
    srt_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.ok, out_ch.found_price, out_ch.found_stock, out_ch.entry_count,
             out_ch.is_empty};
      if (due_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("error: result transfer with nothing pending");
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: expected ok=%0d price=%0h stock=%0h count=%0d empty=%0d",
                     want.ok, want.found_price, want.found_stock, want.entry_count,
                     want.is_empty);
            $display("          actual   ok=%0d price=%0h stock=%0h count=%0d empty=%0d",
                     got.ok, got.found_price, got.found_stock, got.entry_count,
                     got.is_empty);
          end
        end
      end
    end
  end

  initial begin
    shelf_fill         = 0;
    fault_count        = 0;
    calm               = 1'b0;
    hold_asked         = 0;
    hold_done          = 0;
    hold_left          = 0;
    out_ch.ready       = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= srt_pkg::OP_INSERT;
    in_ch.key         <= '0;
    in_ch.price_cents <= '0;
    in_ch.stock_count <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_field_extremes();
    test_equal_keys();
    test_drain_to_empty();
    test_output_backpressure();
    test_random_traffic();

    repeat (srt_pkg::CAPACITY + 8) @(posedge clk);
    if (fault_count == 0 && due_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/srt_pkg.sv
rtl/srt_in_if.sv
rtl/srt_out_if.sv
rtl/srt_ram.sv
rtl/srt_ctrl.sv
rtl/sorted_record_table.sv
tb/testbench.sv
